@@ hw/rtl/mfdf_pkg.sv @@
// Shared types and constants for the milli fixed-point decimal formatter.
package mfdf_pkg;

  localparam int CHAR_W   = 6;
  localparam int PLACES_W = 2;
  localparam int DIGIT_W  = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 6'd46;

  typedef logic [DIGIT_W-1:0] digit_t;

  // Converter status toward the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } conv_stat_t;

endpackage

@@ hw/rtl/mfdf_if.sv @@
// Valid/ready channel interfaces for the formatter input and character output.
interface mfdf_in_if import mfdf_pkg::*; #(
  parameter int VALUE_BITS = 31
) ();
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value_milli;
  logic [PLACES_W-1:0]   decimal_places;

  modport source (output valid, value_milli, decimal_places, input ready);
  modport sink   (input valid, value_milli, decimal_places, output ready);
endinterface

interface mfdf_out_if import mfdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;

  modport source (output valid, out_char, last_char, input ready);
  modport sink   (input valid, out_char, last_char, output ready);
endinterface

@@ hw/rtl/mfdf_bcd_conv.sv @@
// Bit-serial binary to BCD converter (shift and add-3), one value bit per cycle.
module mfdf_bcd_conv import mfdf_pkg::*; #(
  parameter int VALUE_BITS = 31,
  parameter int NDIG       = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] value,
  output digit_t [NDIG-1:0]     digits,
  output conv_stat_t            stat
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  logic [VALUE_BITS-1:0] val_r;
  digit_t [NDIG-1:0]     bcd_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  digit_t [NDIG-1:0]     adj;
  digit_t [NDIG-1:0]     bcd_nxt;

  // add 3 to every digit of 5 or more, then shift the whole chain left
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i] = (bcd_r[i] >= digit_t'(5)) ? bcd_r[i] + digit_t'(3) : bcd_r[i];
    end
    bcd_nxt[0] = {adj[0][DIGIT_W-2:0], val_r[VALUE_BITS-1]};
    for (int i = 1; i < NDIG; i++) begin
      bcd_nxt[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        val_r  <= value;
        bcd_r  <= '0;
        cnt_r  <= CNT_W'(VALUE_BITS);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        bcd_r <= bcd_nxt;
        val_r <= {val_r[VALUE_BITS-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign digits    = bcd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

@@ hw/rtl/milli_fixed_decimal_formatter.sv @@
// Top level of the milli fixed-point decimal formatter.
//
// Input channel in_ch: one transfer carries value_milli (value in units of
// 10^-FRACTION_DIGITS) and decimal_places (0..3, saturated to
// FRACTION_DIGITS). Output channel out_ch: one transfer per ASCII character,
// most significant first; last_char marks the final character of a number.
// Output is the integer part with leading zeros dropped (a single '0' below
// one unit), then, if decimal_places is nonzero, '.' and the truncated
// fraction digits.
//
// Timing: after an input transfer the shift/add-3 converter runs (one value
// bit per cycle); when it is done, the sequencer moves to the integer digits
// and registers the first character. Characters then leave at one per cycle
// while the receiver is ready. in_ch.ready is high only while the sequencer
// is idle; the last character of a number may still sit in the output
// register when the next value is taken. A stalled receiver holds the output
// register and the sequencer. Reset (rst_n low, synchronous) empties the
// output register and returns the sequencer to idle.
module milli_fixed_decimal_formatter import mfdf_pkg::*; #(
  parameter int VALUE_BITS      = 31,
  parameter int FRACTION_DIGITS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  mfdf_in_if.sink     in_ch,
  mfdf_out_if.source  out_ch
);

  // decimal digits of 2^VALUE_BITS-1 is floor(VALUE_BITS*log10(2))+1;
  // at least one integer digit above the fraction is always kept
  localparam int BIN_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int NDIG  = (BIN_DIGITS > FRACTION_DIGITS + 1) ? BIN_DIGITS
                                                            : FRACTION_DIGITS + 1;
  localparam int POS_W = $clog2(NDIG);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_INT,
    S_POINT,
    S_FRAC
  } state_t;

  state_t              state_r;
  logic [POS_W-1:0]    pos_r;      // digit being emitted
  logic [POS_W-1:0]    fend_r;     // last fraction digit position
  logic                no_frac_r;  // zero places: integer part ends the number
  logic                out_valid_r;
  logic [CHAR_W-1:0]   out_char_r;
  logic                out_last_r;

  digit_t [NDIG-1:0]   digits;
  conv_stat_t          cstat;
  logic                in_xfer;
  logic                slot_free;
  logic                emit_char;
  logic [PLACES_W-1:0] places_sat;
  logic [POS_W-1:0]    lead_pos;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  // output register can take a character this cycle
  assign slot_free   = !out_valid_r || out_ch.ready;
  // a character is loaded into the output register this cycle
  assign emit_char   = slot_free &&
                       (state_r == S_INT || state_r == S_POINT || state_r == S_FRAC);

  always_comb begin
    if (int'(in_ch.decimal_places) > FRACTION_DIGITS) begin
      places_sat = PLACES_W'(FRACTION_DIGITS);
    end else begin
      places_sat = in_ch.decimal_places;
    end
  end

  // highest nonzero integer digit; the units digit always prints
  always_comb begin
    lead_pos = POS_W'(FRACTION_DIGITS);
    for (int i = FRACTION_DIGITS + 1; i < NDIG; i++) begin
      if (digits[i] != '0) begin
        lead_pos = POS_W'(i);
      end
    end
  end

  mfdf_bcd_conv #(
    .VALUE_BITS (VALUE_BITS),
    .NDIG       (NDIG)
  ) u_conv (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_xfer),
    .value  (in_ch.value_milli),
    .digits (digits),
    .stat   (cstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
    end else begin
      if (emit_char) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            fend_r    <= POS_W'(FRACTION_DIGITS - int'(places_sat));
            no_frac_r <= (places_sat == '0);
            state_r   <= S_CONV;
          end
        end
        S_CONV: begin
          if (cstat.done) begin
            pos_r   <= lead_pos;
            state_r <= S_INT;
          end
        end
        S_INT: begin
          if (slot_free) begin
            out_char_r  <= CHAR_ZERO + CHAR_W'(digits[pos_r]);
            out_last_r  <= no_frac_r && (pos_r == POS_W'(FRACTION_DIGITS));
            if (pos_r == POS_W'(FRACTION_DIGITS)) begin
              state_r <= no_frac_r ? S_IDLE : S_POINT;
            end else begin
              pos_r <= pos_r - POS_W'(1);
            end
          end
        end
        S_POINT: begin
          if (slot_free) begin
            out_char_r  <= CHAR_POINT;
            out_last_r  <= 1'b0;
            pos_r       <= POS_W'(FRACTION_DIGITS - 1);
            state_r     <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (slot_free) begin
            out_char_r  <= CHAR_ZERO + CHAR_W'(digits[pos_r]);
            out_last_r  <= (pos_r == fend_r);
            if (pos_r == fend_r) begin
              state_r <= S_IDLE;
            end else begin
              pos_r <= pos_r - POS_W'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_char  = out_char_r;
  assign out_ch.last_char = out_last_r;

  // converter only finishes while the sequencer waits for it
  a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
    cstat.done |-> state_r == S_CONV)
    else $error("converter done outside conversion");

  // an accepted value starts the converter on the next cycle
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> cstat.busy && state_r == S_CONV)
    else $error("converter not started after input transfer");

  // integer digits never run below the units position
  a_int_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INT |-> pos_r >= POS_W'(FRACTION_DIGITS) && pos_r < POS_W'(NDIG))
    else $error("integer digit position out of range");

  // fraction digits stay between the point and the last requested place
  a_frac_pos: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FRAC |-> pos_r >= fend_r && pos_r < POS_W'(FRACTION_DIGITS))
    else $error("fraction digit position out of range");

endmodule
